@@ rtl/gpf_pkg.sv @@
// gpf_pkg: shared types, constants and arithmetic helpers for the grid pressure/flow block.
// No dependencies; other files refer to it by scoped names, and the testbench also imports it.
`default_nettype none

package gpf_pkg;

  // grid defaults
  localparam int GRID_ROWS_DEF    = 20;
  localparam int GRID_COLUMNS_DEF = 14;

  // item and config widths
  localparam int OP_W       = 2;
  localparam int IDX_W      = 9;
  localparam int DATA_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // op codes
  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 3'd4;

  // config reset values
  localparam logic [16:0] MOMENTUM_RST   = 17'd13107;
  localparam logic [16:0] FLOW_GAIN_RST  = 17'd13107;
  localparam logic [15:0] BASE_RST       = 16'd60;
  localparam logic [14:0] AMPLITUDE_RST  = 15'd40;
  localparam logic [23:0] PHASE_STEP_RST = 24'd479349;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // phase in Q3.24 radians, kept below two pi
  localparam int PHASE_W = 27;
  localparam logic [PHASE_W:0]   TWO_PI_Q24  = 28'd105414357;
  localparam logic [PHASE_W-1:0] PI_Q24      = 27'd52707179;
  localparam logic [PHASE_W-1:0] HALF_PI_Q24 = 27'd26353589;

  // CORDIC
  localparam int COR_W      = 20;
  localparam int COR_STEPS  = 17;
  localparam int COR_STEP_W = 5;
  localparam logic signed [COR_W-1:0] COR_GAIN = 20'sd39797;

  function automatic logic signed [COR_W-1:0] cor_arc(input logic [COR_STEP_W-1:0] k);
    case (k)
      5'd0:    cor_arc = COR_W'(51472);
      5'd1:    cor_arc = COR_W'(30386);
      5'd2:    cor_arc = COR_W'(16055);
      5'd3:    cor_arc = COR_W'(8150);
      5'd4:    cor_arc = COR_W'(4091);
      5'd5:    cor_arc = COR_W'(2047);
      5'd6:    cor_arc = COR_W'(1024);
      5'd7:    cor_arc = COR_W'(512);
      5'd8:    cor_arc = COR_W'(256);
      5'd9:    cor_arc = COR_W'(128);
      5'd10:   cor_arc = COR_W'(64);
      5'd11:   cor_arc = COR_W'(32);
      5'd12:   cor_arc = COR_W'(16);
      5'd13:   cor_arc = COR_W'(8);
      5'd14:   cor_arc = COR_W'(4);
      5'd15:   cor_arc = COR_W'(2);
      5'd16:   cor_arc = COR_W'(1);
      default: cor_arc = '0;
    endcase
  endfunction

  // clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // controller to datapath commands
  typedef struct packed {
    logic                  clr_wr;
    logic                  item_take;
    logic                  tick_start;
    logic                  load_wr;
    logic                  rd_node;
    logic                  rd_cap;
    logic                  cor_init;
    logic                  cor_step;
    logic                  drv_mul;
    logic                  drv_add;
    logic                  f_rd;
    logic                  f_mul;
    logic                  f_mul2;
    logic                  f_wr;
    logic                  p_rd;
    logic                  p_wr;
    logic                  out_load;
    logic                  first_col;
    logic                  last_col;
    logic                  first_row;
    logic                  last_row;
    logic [COR_STEP_W-1:0] step;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/gpf_if.sv @@
// gpf_if: valid/ready channel interfaces for the input item and the result item.
// Depends on gpf_pkg for field widths.
`default_nettype none

interface gpf_in_if;
  logic                               valid;
  logic                               ready;
  logic [gpf_pkg::OP_W-1:0]           op;
  logic [gpf_pkg::IDX_W-1:0]          node_index;
  logic signed [gpf_pkg::DATA_W-1:0]  pressure_value;
  modport source(output valid, op, node_index, pressure_value, input ready);
  modport sink(input valid, op, node_index, pressure_value, output ready);
endinterface

interface gpf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [gpf_pkg::DATA_W-1:0]  node_pressure;
  logic signed [gpf_pkg::DATA_W-1:0]  node_flow_x;
  logic signed [gpf_pkg::DATA_W-1:0]  node_flow_y;
  logic [gpf_pkg::DATA_W-1:0]         frame_number;
  modport source(output valid, node_pressure, node_flow_x, node_flow_y, frame_number,
                 input ready);
  modport sink(input valid, node_pressure, node_flow_x, node_flow_y, frame_number,
               output ready);
endinterface

`default_nettype wire

@@ rtl/grid_pressure_flow_step.sv @@
// grid_pressure_flow_step: top level; joins the sequencer and the datapath to the channels.
// Depends on gpf_pkg, gpf_if, gpf_ctrl, gpf_dp (and gpf_ram below it).
//
//   channel   dir   handshake          content
//   in_ch     in    valid/ready        op, node_index, pressure_value
//   out_ch    out   valid/ready        node_pressure, node_flow_x, node_flow_y, frame_number
//   cfg_*     in    cfg_we only        cfg_index selects register, cfg_data value
//
// After accept: load writes the pressure store, read addresses the stores and then captures
// the data, and an unused op goes straight to its result; a tick runs setup, 17 CORDIC
// steps and the drive multiply and add, then walks the N = rows*columns nodes for flows
// (read, two multiply stages, write) and again for pressure (read, write), not overlapped.
// After reset a clearing pass over all N nodes zeroes the stores; in_ch.ready stays low meanwhile.
// in_ch.ready is high whenever the sequencer is idle, even while a result waits in the
// output register; a finished item then holds until out_ch takes the earlier result.
`default_nettype none

module grid_pressure_flow_step #(
  parameter int GRID_ROWS    = gpf_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLUMNS = gpf_pkg::GRID_COLUMNS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  gpf_in_if.sink                                 in_ch,
  gpf_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [gpf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gpf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int NODES = GRID_ROWS * GRID_COLUMNS;
  localparam int AW    = $clog2(NODES);

  gpf_pkg::cmd_t  cmd;      // sequencer commands, one step per cycle while not held in the done state
  logic [AW-1:0]  node;     // node being walked
  logic           in_ready;
  logic           out_valid;

  gpf_ctrl #(.GRID_ROWS(GRID_ROWS), .GRID_COLUMNS(GRID_COLUMNS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .out_ready (out_ch.ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd),
    .node      (node)
  );

  // payload side: stores, tick arithmetic, result register
  gpf_dp #(.GRID_ROWS(GRID_ROWS), .GRID_COLUMNS(GRID_COLUMNS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .node         (node),
    .in_idx       (in_ch.node_index),
    .in_pv        (in_ch.pressure_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_pressure (out_ch.node_pressure),
    .out_flow_x   (out_ch.node_flow_x),
    .out_flow_y   (out_ch.node_flow_y),
    .out_frame    (out_ch.frame_number)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire

@@ rtl/gpf_ram.sv @@
// gpf_ram: generic single-write, dual-read RAM with registered read data.
// Depends on gpf_pkg for default sizes.
`default_nettype none

module gpf_ram #(
  parameter int WIDTH = gpf_pkg::DATA_W,
  parameter int DEPTH = gpf_pkg::GRID_ROWS_DEF * gpf_pkg::GRID_COLUMNS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

@@ rtl/gpf_ctrl.sv @@
// gpf_ctrl: sequencer for load, read and tick items, node walk counters and output valid.
// Depends on gpf_pkg for cmd_t and op codes.
`default_nettype none

module gpf_ctrl #(
  parameter int GRID_ROWS    = gpf_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLUMNS = gpf_pkg::GRID_COLUMNS_DEF,
  localparam int NODES = GRID_ROWS * GRID_COLUMNS,
  localparam int AW    = $clog2(NODES)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic [gpf_pkg::OP_W-1:0] in_op,
  input  wire logic                     out_ready,
  output logic                          in_ready,
  output logic                          out_valid,
  output gpf_pkg::cmd_t                 cmd,
  output logic [AW-1:0]                 node
);

  localparam int CLW = $clog2(GRID_COLUMNS);
  localparam int RLW = $clog2(GRID_ROWS);

  typedef enum logic [15:0] {
    ST_CLEAR = 16'b0000_0000_0000_0001,
    ST_IDLE  = 16'b0000_0000_0000_0010,
    ST_LOAD  = 16'b0000_0000_0000_0100,
    ST_RD0   = 16'b0000_0000_0000_1000,
    ST_RD1   = 16'b0000_0000_0001_0000,
    ST_CINIT = 16'b0000_0000_0010_0000,
    ST_COR   = 16'b0000_0000_0100_0000,
    ST_DRVM  = 16'b0000_0000_1000_0000,
    ST_DRVA  = 16'b0000_0001_0000_0000,
    ST_F0    = 16'b0000_0010_0000_0000,
    ST_F1    = 16'b0000_0100_0000_0000,
    ST_F2    = 16'b0000_1000_0000_0000,
    ST_F3    = 16'b0001_0000_0000_0000,
    ST_P0    = 16'b0010_0000_0000_0000,
    ST_P1    = 16'b0100_0000_0000_0000,
    ST_DONE  = 16'b1000_0000_0000_0000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [AW-1:0]                   node_r, node_nxt;
  logic [CLW-1:0]                  col_r, col_nxt;
  logic [RLW-1:0]                  row_r, row_nxt;
  logic [gpf_pkg::COR_STEP_W-1:0]  step_r, step_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            last_node, last_col, last_row;

  assign last_node = (node_r == AW'(NODES - 1));
  assign last_col  = (col_r == CLW'(GRID_COLUMNS - 1));
  assign last_row  = (row_r == RLW'(GRID_ROWS - 1));

  assign node      = node_r;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    node_nxt  = node_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    step_nxt  = step_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.first_col = (col_r == '0);
    cmd.last_col  = last_col;
    cmd.first_row = (row_r == '0);
    cmd.last_row  = last_row;
    cmd.step      = step_r;

    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        node_nxt   = node_r + AW'(1);
        if (last_node) begin
          node_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.item_take  = 1'b1;
          cmd.tick_start = (in_op == gpf_pkg::OP_TICK);
          unique case (in_op)
            gpf_pkg::OP_LOAD: state_nxt = ST_LOAD;
            gpf_pkg::OP_TICK: state_nxt = ST_CINIT;
            gpf_pkg::OP_READ: state_nxt = ST_RD0;
            default:          state_nxt = ST_DONE;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.load_wr = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_RD0: begin
        cmd.rd_node = 1'b1;
        state_nxt   = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd_cap = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_CINIT: begin
        cmd.cor_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = ST_COR;
      end
      ST_COR: begin
        cmd.cor_step = 1'b1;
        step_nxt     = step_r + gpf_pkg::COR_STEP_W'(1);
        if (step_r == gpf_pkg::COR_STEP_W'(gpf_pkg::COR_STEPS - 1)) begin
          state_nxt = ST_DRVM;
        end
      end
      ST_DRVM: begin
        cmd.drv_mul = 1'b1;
        state_nxt   = ST_DRVA;
      end
      ST_DRVA: begin
        cmd.drv_add = 1'b1;
        node_nxt    = '0;
        col_nxt     = '0;
        row_nxt     = '0;
        state_nxt   = ST_F0;
      end
      ST_F0: begin
        cmd.f_rd  = 1'b1;
        state_nxt = ST_F1;
      end
      ST_F1: begin
        cmd.f_mul = 1'b1;
        state_nxt = ST_F2;
      end
      ST_F2: begin
        cmd.f_mul2 = 1'b1;
        state_nxt  = ST_F3;
      end
      ST_F3: begin
        cmd.f_wr = 1'b1;
        if (last_node) begin
          node_nxt  = '0;
          col_nxt   = '0;
          row_nxt   = '0;
          state_nxt = ST_P0;
        end else begin
          node_nxt  = node_r + AW'(1);
          col_nxt   = last_col ? '0 : col_r + CLW'(1);
          row_nxt   = last_col ? row_r + RLW'(1) : row_r;
          state_nxt = ST_F0;
        end
      end
      ST_P0: begin
        cmd.p_rd  = 1'b1;
        state_nxt = ST_P1;
      end
      ST_P1: begin
        cmd.p_wr = 1'b1;
        if (last_node) begin
          node_nxt  = '0;
          col_nxt   = '0;
          row_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          node_nxt  = node_r + AW'(1);
          col_nxt   = last_col ? '0 : col_r + CLW'(1);
          row_nxt   = last_col ? row_r + RLW'(1) : row_r;
          state_nxt = ST_P0;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      node_r      <= '0;
      col_r       <= '0;
      row_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      node_r      <= node_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/gpf_dp.sv @@
// gpf_dp: node stores, config registers, frame/phase, CORDIC sine, flow and pressure math.
// Depends on gpf_pkg and gpf_ram.
`default_nettype none

module gpf_dp #(
  parameter int GRID_ROWS    = gpf_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLUMNS = gpf_pkg::GRID_COLUMNS_DEF,
  localparam int NODES = GRID_ROWS * GRID_COLUMNS,
  localparam int AW    = $clog2(NODES)
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire gpf_pkg::cmd_t                       cmd,
  input  wire logic [AW-1:0]                       node,
  input  wire logic [gpf_pkg::IDX_W-1:0]           in_idx,
  input  wire logic signed [gpf_pkg::DATA_W-1:0]   in_pv,
  input  wire logic                                cfg_we,
  input  wire logic [gpf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gpf_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic signed [gpf_pkg::DATA_W-1:0]        out_pressure,
  output logic signed [gpf_pkg::DATA_W-1:0]        out_flow_x,
  output logic signed [gpf_pkg::DATA_W-1:0]        out_flow_y,
  output logic [gpf_pkg::DATA_W-1:0]               out_frame
);

  localparam int CW = gpf_pkg::COR_W;
  localparam int PW = gpf_pkg::PHASE_W;

  // config
  logic [16:0]               momentum_r, gain_r;
  logic signed [15:0]        base_r;
  logic [14:0]               amp_r;
  logic [23:0]               pstep_r;
  logic [16:0]               m_eff, g_eff, om_eff;
  logic signed [17:0]        ms, gs, oms;

  // item, frame, phase
  logic [gpf_pkg::IDX_W-1:0] item_idx_r;
  logic signed [31:0]        item_pv_r;
  logic                      idx_ok;
  logic [AW-1:0]             idx_addr;
  logic [31:0]               frame_r;
  logic [PW-1:0]             phase_r;
  logic [PW:0]               psum;

  // CORDIC and drive
  logic signed [CW-1:0]      cx_r, cy_r, cz_r, dxc, dyc, arc, sine;
  logic                      neg_r, fneg;
  logic [PW-1:0]             f1, f2;
  logic signed [35:0]        drv_prod_r;
  logic signed [36:0]        dsum;
  logic signed [31:0]        drive_r;

  // flow pass
  logic signed [31:0]        pcur_r, pnext_r, oldx_r, oldy_r, p_i, p_d;
  logic signed [32:0]        dx, dy;
  logic signed [50:0]        gx_r, gy_r;
  logic signed [51:0]        gxr, gyr;
  logic signed [35:0]        qx, qy;
  logic signed [49:0]        mx_r, my_r;
  logic signed [53:0]        nx_r, ny_r;
  logic signed [54:0]        sx, sy;
  logic signed [31:0]        newx, newy;

  // pressure pass
  logic signed [31:0]        fxleft_r, p_self;
  logic signed [34:0]        psum2;
  logic signed [31:0]        newp;

  // result
  logic signed [31:0]        res_p_r, res_fx_r, res_fy_r;

  // memories
  logic                      p_we, fx_we, fy_we;
  logic [AW-1:0]             p_wa, p_ra, p_rb, fx_ra, fy_ra, fy_rb;
  logic [31:0]               p_wd, fx_wd, fy_wd;
  logic [31:0]               p_da, p_db, fx_da, fy_da, fy_db;
  logic [AW-1:0]             node_p1, node_pc, node_mc;

  assign m_eff  = (momentum_r > gpf_pkg::ONE_Q16) ? gpf_pkg::ONE_Q16 : momentum_r;
  assign g_eff  = (gain_r > gpf_pkg::ONE_Q16) ? gpf_pkg::ONE_Q16 : gain_r;
  assign om_eff = gpf_pkg::ONE_Q16 - m_eff;
  assign ms     = $signed({1'b0, m_eff});
  assign gs     = $signed({1'b0, g_eff});
  assign oms    = $signed({1'b0, om_eff});

  assign idx_ok   = (32'(item_idx_r) < NODES);
  assign idx_addr = AW'(item_idx_r);
  assign node_p1  = node + AW'(1);
  assign node_pc  = node + AW'(GRID_COLUMNS);
  assign node_mc  = node - AW'(GRID_COLUMNS);

  // address and write selection
  always_comb begin
    p_ra  = node;
    p_rb  = node;
    fx_ra = node;
    fy_ra = node;
    fy_rb = cmd.first_row ? node : node_mc;
    if (cmd.rd_node) begin
      p_ra  = idx_addr;
      fx_ra = idx_addr;
      fy_ra = idx_addr;
    end else if (cmd.f_rd) begin
      p_ra = cmd.last_col ? node : node_p1;
      p_rb = cmd.last_row ? node : node_pc;
    end

    p_we  = 1'b0;
    p_wa  = node;
    p_wd  = '0;
    if (cmd.clr_wr) begin
      p_we = 1'b1;
    end else if (cmd.load_wr) begin
      p_we = idx_ok;
      p_wa = idx_addr;
      p_wd = item_pv_r;
    end else if (cmd.p_wr) begin
      p_we = 1'b1;
      p_wd = newp;
    end

    fx_we = cmd.clr_wr | cmd.f_wr;
    fx_wd = cmd.f_wr ? newx : '0;
    fy_we = cmd.clr_wr | (cmd.f_wr & ~cmd.last_row);
    fy_wd = cmd.f_wr ? newy : '0;
  end

  gpf_ram #(.WIDTH(32), .DEPTH(NODES)) u_p_ram (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd),
    .raddr_a(p_ra), .raddr_b(p_rb), .rdata_a(p_da), .rdata_b(p_db)
  );

  gpf_ram #(.WIDTH(32), .DEPTH(NODES)) u_fx_ram (
    .clk(clk), .we(fx_we), .waddr(node), .wdata(fx_wd),
    .raddr_a(fx_ra), .raddr_b(fx_ra), .rdata_a(fx_da), .rdata_b()
  );

  gpf_ram #(.WIDTH(32), .DEPTH(NODES)) u_fy_ram (
    .clk(clk), .we(fy_we), .waddr(node), .wdata(fy_wd),
    .raddr_a(fy_ra), .raddr_b(fy_rb), .rdata_a(fy_da), .rdata_b(fy_db)
  );

  // phase advance and quadrant fold
  always_comb begin
    psum = {1'b0, phase_r} + (PW + 1)'(pstep_r);
    if (psum >= gpf_pkg::TWO_PI_Q24) begin
      psum = psum - gpf_pkg::TWO_PI_Q24;
    end
    fneg = (phase_r >= gpf_pkg::PI_Q24);
    f1   = fneg ? phase_r - gpf_pkg::PI_Q24 : phase_r;
    f2   = (f1 > gpf_pkg::HALF_PI_Q24) ? gpf_pkg::PI_Q24 - f1 : f1;
  end

  // CORDIC micro-rotation
  assign dxc  = cy_r >>> cmd.step;
  assign dyc  = cx_r >>> cmd.step;
  assign arc  = gpf_pkg::cor_arc(cmd.step);
  assign sine = neg_r ? -cy_r : cy_r;
  assign dsum = 37'($signed({base_r, 16'h0000})) + 37'(drv_prod_r);

  // flow math
  assign p_i  = cmd.first_col ? drive_r : pcur_r;
  assign p_d  = cmd.first_col ? drive_r : $signed(p_db);
  assign dx   = cmd.last_col ? 33'(p_i) : 33'(p_i) - 33'($signed(p_da));
  assign dy   = 33'(p_i) - 33'(p_d);
  assign gxr  = 52'(gx_r) + 52'sd32768;
  assign gyr  = 52'(gy_r) + 52'sd32768;
  assign qx   = $signed(gxr[51:16]);
  assign qy   = $signed(gyr[51:16]);
  assign sx   = 55'(mx_r) + 55'(nx_r) + 55'sd32768;
  assign sy   = 55'(my_r) + 55'(ny_r) + 55'sd32768;
  assign newx = gpf_pkg::sat32(64'($signed(sx[54:16])));
  assign newy = gpf_pkg::sat32(64'($signed(sy[54:16])));

  // pressure update: own outflows leave, left and upper outflows arrive
  assign p_self = cmd.first_col ? drive_r : $signed(p_da);
  assign psum2  = 35'(p_self) - 35'($signed(fy_da)) - 35'($signed(fx_da))
                + (cmd.first_col ? 35'sd0 : 35'(fxleft_r))
                + (cmd.first_row ? 35'sd0 : 35'($signed(fy_db)));
  assign newp   = gpf_pkg::sat32(64'(psum2));

  // control-like state: config, frame, phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      momentum_r <= gpf_pkg::MOMENTUM_RST;
      gain_r     <= gpf_pkg::FLOW_GAIN_RST;
      base_r     <= $signed(gpf_pkg::BASE_RST);
      amp_r      <= gpf_pkg::AMPLITUDE_RST;
      pstep_r    <= gpf_pkg::PHASE_STEP_RST;
      frame_r    <= '0;
      phase_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          gpf_pkg::CFG_MOMENTUM:   momentum_r <= cfg_data[16:0];
          gpf_pkg::CFG_FLOW_GAIN:  gain_r     <= cfg_data[16:0];
          gpf_pkg::CFG_BASE:       base_r     <= $signed(cfg_data[15:0]);
          gpf_pkg::CFG_AMPLITUDE:  amp_r      <= cfg_data[14:0];
          gpf_pkg::CFG_PHASE_STEP: pstep_r    <= cfg_data[23:0];
          default: ;
        endcase
      end
      if (cmd.tick_start) begin
        frame_r <= frame_r + 32'd1;
        phase_r <= psum[PW-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.item_take) begin
      item_idx_r <= in_idx;
      item_pv_r  <= in_pv;
      res_p_r    <= '0;
      res_fx_r   <= '0;
      res_fy_r   <= '0;
    end
    if (cmd.rd_cap) begin
      res_p_r  <= idx_ok ? $signed(p_da)  : 32'sd0;
      res_fx_r <= idx_ok ? $signed(fx_da) : 32'sd0;
      res_fy_r <= idx_ok ? $signed(fy_da) : 32'sd0;
    end
    if (cmd.cor_init) begin
      cx_r  <= gpf_pkg::COR_GAIN;
      cy_r  <= '0;
      // folded phase is at most half pi, so bit PW-1 is always clear
      cz_r  <= $signed({2'b00, f2[PW-2:8]});
      neg_r <= fneg;
    end
    if (cmd.cor_step) begin
      if (!cz_r[CW-1]) begin
        cx_r <= cx_r - dxc;
        cy_r <= cy_r + dyc;
        cz_r <= cz_r - arc;
      end else begin
        cx_r <= cx_r + dxc;
        cy_r <= cy_r - dyc;
        cz_r <= cz_r + arc;
      end
    end
    if (cmd.drv_mul) begin
      drv_prod_r <= $signed({1'b0, amp_r}) * sine;
    end
    if (cmd.drv_add) begin
      drive_r <= gpf_pkg::sat32(64'(dsum));
    end
    if (cmd.f_mul) begin
      gx_r    <= gs * dx;
      gy_r    <= gs * dy;
      oldx_r  <= $signed(fx_da);
      oldy_r  <= $signed(fy_da);
      pnext_r <= $signed(p_da);
    end
    if (cmd.f_mul2) begin
      mx_r <= ms * oldx_r;
      my_r <= ms * oldy_r;
      nx_r <= oms * qx;
      ny_r <= oms * qy;
    end
    if (cmd.f_wr) begin
      pcur_r <= pnext_r;
    end
    if (cmd.p_wr) begin
      fxleft_r <= $signed(fx_da);
    end
    if (cmd.out_load) begin
      out_pressure <= res_p_r;
      out_flow_x   <= res_fx_r;
      out_flow_y   <= res_fy_r;
      out_frame    <= frame_r;
    end
  end

endmodule

`default_nettype wire

@@ rtl/gpf_checker.sv @@
// gpf_checker: port-level assertions for grid_pressure_flow_step, bound to the top level.
// Depends on gpf_if.
`default_nettype none

module gpf_checker (
  input wire logic   clk,
  input wire logic   rst_n,
  gpf_in_if.sink     in_ch,
  gpf_out_if.source  out_ch
);

  // one item in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("item accepted while previous item still in work");

  // input ready is low as reset lifts, at the start of the post-reset clearing pass
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ch.ready)
    else $error("input ready during clearing pass");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=>
      (out_ch.valid && $stable(out_ch.frame_number) && $stable(out_ch.node_pressure)))
    else $error("stalled result changed");

  // with the output empty, no result shows up in the cycle right after an accept
  a_no_out_while_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !out_ch.valid) |=> !out_ch.valid)
    else $error("result appeared in the cycle after accept");

endmodule

bind grid_pressure_flow_step gpf_checker u_gpf_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

`default_nettype wire

@@ tb/sv/grid_pressure_flow_step_tb.sv @@
// grid_pressure_flow_step_tb: self-checking bench for the grid pressure/flow block.
// Depends on gpf_pkg, gpf_if and the grid_pressure_flow_step RTL.
// Predicts each result item with a bit-exact grid model held in a scoreboard class.

class flow_scoreboard;
  typedef struct {
    int unsigned frame;
    int          pres;
    int          fx;
    int          fy;
  } node_view_t;

  localparam int ROWS  = gpf_pkg::GRID_ROWS_DEF;
  localparam int COLS  = gpf_pkg::GRID_COLUMNS_DEF;
  localparam int NODES = ROWS * COLS;
  localparam longint ONE = 65536;

  int          pres_q[NODES];
  int          flow_x_q[NODES];
  int          flow_y_q[NODES];
  int unsigned frame_cnt;
  bit [31:0]   phase_q24;
  int unsigned momentum, flow_gain, amplitude, phase_step;
  int          base;
  int          arc_q16[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
                               128, 64, 32, 16, 8, 4, 2, 1};
  node_view_t  pending_q[$];
  int          mismatches;
  int          results_seen;

  function new();
    for (int i = 0; i < NODES; i++) begin
      pres_q[i] = 0; flow_x_q[i] = 0; flow_y_q[i] = 0;
    end
    frame_cnt = 0; phase_q24 = 0;
    momentum = 13107; flow_gain = 13107; base = 60; amplitude = 40; phase_step = 479349;
    mismatches = 0; results_seen = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [23:0] val);
    case (idx)
      gpf_pkg::CFG_MOMENTUM:   momentum = val[16:0];
      gpf_pkg::CFG_FLOW_GAIN:  flow_gain = val[16:0];
      gpf_pkg::CFG_BASE:       base = $signed(val[15:0]);
      gpf_pkg::CFG_AMPLITUDE:  amplitude = val[14:0];
      gpf_pkg::CFG_PHASE_STEP: phase_step = val;
      default: ;
    endcase
  endfunction

  function int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  // round to nearest, ties up: floor((v + half) / 2^16)
  function longint round16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function longint cordic_sine(bit [31:0] ph);
    bit        neg;
    bit [31:0] p;
    longint    x, y, z, dx, dy;
    neg = 0; p = ph; x = 39797; y = 0;
    if (p >= 32'd52707179) begin
      p -= 32'd52707179; neg = 1;
    end
    if (p > 32'd26353589) p = 32'd52707179 - p;
    z = longint'(p >> 8);
    for (int i = 0; i < 17; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arc_q16[i];
      end else begin
        x += dx; y -= dy; z += arc_q16[i];
      end
    end
    return neg ? -y : y;
  endfunction

  function int relax_flow(int old, longint diff);
    longint m, g, q;
    m = (momentum > ONE) ? ONE : longint'(momentum);
    g = (flow_gain > ONE) ? ONE : longint'(flow_gain);
    q = round16(g * diff);
    return clamp32(round16(m * longint'(old) + (ONE - m) * q));
  endfunction

  function void advance_grid();
    longint drive, p;
    int     inflow;
    frame_cnt++;
    phase_q24 += phase_step;
    if (phase_q24 >= 32'd105414357) phase_q24 -= 32'd105414357;
    drive = longint'(base) * ONE + longint'(amplitude) * cordic_sine(phase_q24);
    inflow = clamp32(drive);
    for (int r = 0; r < ROWS; r++) pres_q[r * COLS] = inflow;
    for (int i = 0; i < NODES; i++) begin
      p = pres_q[i];
      if (i / COLS != ROWS - 1)
        flow_y_q[i] = relax_flow(flow_y_q[i], p - pres_q[i + COLS]);
      if (i % COLS != COLS - 1)
        flow_x_q[i] = relax_flow(flow_x_q[i], p - pres_q[i + 1]);
      else
        flow_x_q[i] = relax_flow(flow_x_q[i], p);
    end
    for (int i = 0; i < NODES; i++) begin
      p = longint'(pres_q[i]) - flow_y_q[i] - flow_x_q[i];
      if (i % COLS > 0) p += flow_x_q[i - 1];
      if (i >= COLS) p += flow_y_q[i - COLS];
      pres_q[i] = clamp32(p);
    end
  endfunction

  // accepted input item: update the model, queue the expected result
  function void note_item(logic [1:0] op, logic [8:0] idx, logic [31:0] pv);
    node_view_t e;
    e.pres = 0; e.fx = 0; e.fy = 0;
    if (op == gpf_pkg::OP_LOAD) begin
      if (idx < NODES) pres_q[idx] = pv;
    end else if (op == gpf_pkg::OP_TICK) begin
      advance_grid();
    end else if (op == gpf_pkg::OP_READ) begin
      if (idx < NODES) begin
        e.pres = pres_q[idx]; e.fx = flow_x_q[idx]; e.fy = flow_y_q[idx];
      end
    end
    e.frame = frame_cnt;
    pending_q.push_back(e);
  endfunction

  function void check_result(int pres, int fx, int fy, int unsigned frame);
    node_view_t e;
    results_seen++;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result item: frame %0d", frame);
      return;
    end
    e = pending_q.pop_front();
    if (e.pres !== pres || e.fx !== fx || e.fy !== fy || e.frame !== frame) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp p=%0d fx=%0d fy=%0d fr=%0d  got p=%0d fx=%0d fy=%0d fr=%0d",
                 e.pres, e.fx, e.fy, e.frame, pres, fx, fy, frame);
    end
  endfunction
endclass

module grid_pressure_flow_step_tb;
  import gpf_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int NODES      = GRID_ROWS_DEF * GRID_COLUMNS_DEF;
  localparam int CYCLE_CAP  = 4000000;
  // sets the long receiver hold-off and the settle after a drain
  localparam int TICK_LAT   = 6 * NODES + 21;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gpf_in_if  in_ch();
  gpf_out_if out_ch();

  grid_pressure_flow_step uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  flow_scoreboard sb = new();

  int send_idle_pct = 0;   // sender gap odds per cycle, percent
  int recv_stall_pct = 0;  // receiver stall odds per cycle, percent
  int hold_left = 0;       // long receiver hold-off, counted down in the receiver process
  int cycle_cnt = 0;
  int items_sent = 0;
  int ticks_sent = 0;
  int reads_sent = 0;

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Both channels sampled at the rising edge; the bench only drives on the falling edge.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_item(in_ch.op, in_ch.node_index, in_ch.pressure_value);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.node_pressure, out_ch.node_flow_x, out_ch.node_flow_y,
                      out_ch.frame_number);
  end

  // Receiver: random stalls, plus the long hold-off that backs the block up.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // One item on in_ch; valid stays high into the next item unless a gap is drawn.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] pv);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.op = op;
    in_ch.node_index = idx;
    in_ch.pressure_value = pv;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (op == OP_TICK) ticks_sent++;
    if (op == OP_READ) reads_sent++;
  endtask

  // Drop valid, let every result arrive, then a short settle before any config write.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (TICK_LAT / 8 + 20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_all(input logic [16:0] m, input logic [16:0] g, input logic [15:0] b,
                           input logic [14:0] a, input logic [23:0] s);
    write_reg(CFG_MOMENTUM, 24'(m));
    write_reg(CFG_FLOW_GAIN, 24'(g));
    write_reg(CFG_BASE, 24'(b));
    write_reg(CFG_AMPLITUDE, 24'(a));
    write_reg(CFG_PHASE_STEP, s);
  endtask

  function automatic logic [DATA_W-1:0] rand_pressure();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3: return $urandom;
      default: return DATA_W'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
    endcase
  endfunction

  // Random mix: reads dominate so flows get observed; ticks are the costly op.
  task automatic random_items(input int count);
    int          pick;
    logic [8:0]  idx;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      idx = ($urandom_range(0, 19) == 0) ? 9'($urandom_range(0, 511))
                                         : 9'($urandom_range(0, NODES - 1));
      if (pick < 14)      send_item(OP_TICK, idx, $urandom);
      else if (pick < 36) send_item(OP_LOAD, idx, rand_pressure());
      else if (pick < 96) send_item(OP_READ, idx, $urandom);
      else                send_item(OP_UNUSED, idx, $urandom);
    end
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
      default: begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.node_index = '0;
    in_ch.pressure_value = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes of index and pressure, bad indexes, unused op, reset config.
    send_item(OP_LOAD, 9'd0, 32'h7FFFFFFF);
    send_item(OP_LOAD, 9'd279, 32'h80000000);
    send_item(OP_LOAD, 9'd280, 32'h12345678);   // past the last node: ignored
    send_item(OP_LOAD, 9'd511, 32'hFFFFFFFF);
    send_item(OP_READ, 9'd0, '0);
    send_item(OP_READ, 9'd279, '0);
    send_item(OP_READ, 9'd280, '0);             // bad index reads back zeros
    send_item(OP_READ, 9'd511, '0);
    send_item(OP_UNUSED, 9'd5, 32'hA5A5A5A5);
    send_item(OP_LOAD, 9'd13, 32'h7FFFFFFF);    // right edge
    send_item(OP_LOAD, 9'd266, 32'h80000000);   // bottom-left
    send_item(OP_TICK, 9'd0, '0);
    send_item(OP_READ, 9'd0, '0);
    send_item(OP_READ, 9'd13, '0);
    send_item(OP_READ, 9'd266, '0);
    send_item(OP_READ, 9'd279, '0);
    send_item(OP_TICK, 9'd170, 32'h55555555);
    send_item(OP_READ, 9'd1, '0);
    send_item(OP_READ, 9'd278, '0);
    drain();

    // Config extremes; the phases rotate through the four idling patterns.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_all(17'd0, 17'd65536, 16'h8000, 15'd32767, 24'hFFFFFF);
        1: write_all(17'h1FFFF, 17'h1FFFF, 16'h7FFF, 15'd0, 24'd0);
        2: write_all(17'd65536, 17'd0, 16'hFFFF, 15'd1, 24'd9576373);
        3: write_all(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
                     16'($urandom), 15'($urandom), 24'($urandom));
        4: write_all(17'd40000, 17'd60000, 16'd100, 15'd32767, 24'd8000000);
        default: write_all(17'd13107, 17'd13107, 16'd60, 15'd40, 24'd479349);
      endcase
      set_idling(ph % 4);
      // one phase backs the block up: the receiver holds off while items keep coming
      if (ph == 2) hold_left = 3 * TICK_LAT;
      random_items(64);
      drain();
    end

    // Stretch with no idling at all at the end.
    set_idling(0);
    random_items(20);
    drain();

    $display("run covered %0d items (%0d ticks, %0d reads) over six register settings",
             items_sent, ticks_sent, reads_sent);
    $display("%0d result items checked, %0d mismatches", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

@@ grid_pressure_flow_step.f @@
rtl/gpf_pkg.sv
rtl/gpf_if.sv
rtl/gpf_ram.sv
rtl/gpf_ctrl.sv
rtl/gpf_dp.sv
rtl/grid_pressure_flow_step.sv
rtl/gpf_checker.sv
tb/sv/grid_pressure_flow_step_tb.sv
